/* hw/rtl/run_length_annotator_unit_assert.svh */
// assertion macros for the run-length annotator
`ifndef RUN_LENGTH_ANNOTATOR_UNIT_ASSERT_SVH
`define RUN_LENGTH_ANNOTATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RLA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define RLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rla_pkg.sv */
// shared types and constants of the run-length annotator
package rla_pkg;

	localparam int RUN_QUEUE_DEPTH = 64;
	localparam int LONG_RUN_LIMIT  = 63;

	localparam int QPTR_W = $clog2(RUN_QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(RUN_QUEUE_DEPTH + 1);
	localparam int QSUM_W = QCNT_W + 1;

	localparam int RUN_W = 24;
	localparam int POS_W = 25;
	localparam int SYM_W = 8;

	localparam logic [RUN_W-1:0] MAX_RUN = 24'hFFFFFF;
	localparam logic [POS_W-1:0] MAX_POS = 25'h1FFFFFF;

	localparam logic [7:0] WORD_FLAG  = 8'h40;
	localparam logic [7:0] SHORT_FLAG = 8'h80;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_PULL   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

endpackage

/* hw/rtl/run_length_annotator_unit.sv */
// run-length annotator: run detection, run queue and encoded entry output
//
// Every item (push, finish or pull) is taken into an input register and
// fully handled there, so the unit sustains one item per clock unless a pull waits.
// A pull loads the output register; the input side only waits when a pull
// sits in the input register while the output register is full and stalled.
// Closed runs are kept in a 64-entry queue memory with one write port and a
// registered read of the next head entry, bypassed when that entry is written
// in the same cycle; the single separator entry holds a queue slot but lives
// in a register. No clearing pass is needed after reset.
`include "run_length_annotator_unit_assert.svh"

module run_length_annotator_unit
	import rla_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       command,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       entry_byte,
	output logic             available,
	output logic             is_last,
	output logic             overflow,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [RUN_W-1:0] cfg_data
);

	function automatic logic [QPTR_W-1:0] slot_at(input logic [QPTR_W-1:0] head,
			input logic [QCNT_W-1:0] cnt);
		logic [QSUM_W-1:0] sum;
		sum = QSUM_W'(head) + QSUM_W'(cnt);
		if (sum >= QSUM_W'(RUN_QUEUE_DEPTH))
			sum = sum - QSUM_W'(RUN_QUEUE_DEPTH);
		return sum[QPTR_W-1:0];
	endfunction

	// input stage
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [SYM_W-1:0] byte_s1;
	logic             fire_s1;

	// block state
	logic [RUN_W-1:0]  sentinel_q;
	logic [SYM_W-1:0]  sym_q, sym_d;
	logic [RUN_W-1:0]  run_q, run_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [QCNT_W-1:0] cnt_q, cnt_d;
	logic [QPTR_W-1:0] head_q, head_d;
	logic [RUN_W-1:0]  emit_q, emit_d;
	logic [1:0]        wbi_q, wbi_d;
	logic              fin_q, fin_d;
	logic              sepf_q, sepf_d;
	logic              ovf_q, ovf_d;
	logic              sep_in_q, sep_in_d;
	logic [QPTR_W-1:0] sep_idx_q, sep_idx_d;

	// queue memory
	logic [RUN_W-1:0]  run_queue_q [RUN_QUEUE_DEPTH];
	logic [RUN_W-1:0]  rdata_q;
	logic              byp_q;
	logic [RUN_W-1:0]  byp_data_q;
	logic              wr_en;
	logic [QPTR_W-1:0] wr_addr;
	logic [RUN_W-1:0]  wr_data;
	logic [RUN_W-1:0]  head_val;

	// results
	logic       out_valid_q;
	logic [7:0] entry_byte_q;
	logic       available_q, is_last_q, overflow_q;
	logic [7:0] res_byte;
	logic       res_avail, res_last;

	logic             enq_run, enq_sep;
	logic [RUN_W-1:0] enq_val;
	logic [RUN_W-1:0] emit_v;
	logic [1:0]       wbi_v;
	logic [5:0]       digit;

	assign cfg_ready  = 1'b1;
	assign fire_s1    = valid_s1 && (cmd_s1 != CMD_PULL || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !fire_s1;
	assign out_valid  = out_valid_q;
	assign entry_byte = entry_byte_q;
	assign available  = available_q;
	assign is_last    = is_last_q;
	assign overflow   = overflow_q;

	assign head_val = (sep_in_q && head_q == sep_idx_q) ? RUN_W'(1) :
		(byp_q ? byp_data_q : rdata_q);

	always_comb begin
		sym_d     = sym_q;
		run_d     = run_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		head_d    = head_q;
		emit_d    = emit_q;
		wbi_d     = wbi_q;
		fin_d     = fin_q;
		sepf_d    = sepf_q;
		ovf_d     = ovf_q;
		sep_in_d  = sep_in_q;
		sep_idx_d = sep_idx_q;
		enq_run   = 1'b0;
		enq_val   = run_q;
		enq_sep   = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = slot_at(head_q, cnt_q);
		wr_data   = run_q;
		res_byte  = 8'd0;
		res_avail = 1'b0;
		res_last  = 1'b0;
		emit_v    = emit_q;
		wbi_v     = wbi_q;
		digit     = 6'd0;

		if (fire_s1) begin
			case (cmd_s1)
				CMD_PUSH: begin
					if (!fin_q) begin
						if (!sepf_q && pos_q == POS_W'(sentinel_q)) begin
							enq_run = (run_q != '0);
							enq_sep = 1'b1;
							sym_d   = byte_s1;
							run_d   = RUN_W'(1);
						end else if (run_q != '0 && byte_s1 == sym_q) begin
							if (run_q == MAX_RUN) begin
								ovf_d   = 1'b1;
								enq_run = 1'b1;
								run_d   = RUN_W'(1);
							end else begin
								run_d = run_q + RUN_W'(1);
							end
						end else begin
							enq_run = (run_q != '0);
							sym_d   = byte_s1;
							run_d   = RUN_W'(1);
						end
						if (pos_q != MAX_POS)
							pos_d = pos_q + POS_W'(1);
					end
				end
				CMD_FINISH: begin
					if (!fin_q) begin
						enq_run = (run_q != '0);
						enq_sep = !sepf_q;
						run_d   = '0;
						fin_d   = 1'b1;
					end
				end
				CMD_PULL: begin
					if (emit_q == '0 && cnt_q != '0) begin
						emit_v = head_val;
						wbi_v  = 2'd0;
						cnt_d  = cnt_q - QCNT_W'(1);
						if (sep_in_q && head_q == sep_idx_q)
							sep_in_d = 1'b0;
						if (head_q == QPTR_W'(RUN_QUEUE_DEPTH - 1))
							head_d = '0;
						else
							head_d = head_q + QPTR_W'(1);
					end
					emit_d = emit_v;
					wbi_d  = wbi_v;
					if (emit_v != '0) begin
						res_avail = 1'b1;
						if (emit_v >= RUN_W'(LONG_RUN_LIMIT) || wbi_v != 2'd0) begin
							case (wbi_v)
								2'd0:    digit = emit_v[5:0];
								2'd1:    digit = emit_v[11:6];
								2'd2:    digit = emit_v[17:12];
								default: digit = emit_v[23:18];
							endcase
							res_byte = {2'b00, digit};
							if (wbi_v == 2'd0)
								res_byte = res_byte | WORD_FLAG;
							if (wbi_v == 2'd3) begin
								wbi_d  = 2'd0;
								emit_d = emit_v - RUN_W'(4);
							end else begin
								wbi_d = wbi_v + 2'd1;
							end
						end else begin
							res_byte = SHORT_FLAG | {2'b00, emit_v[5:0]};
							emit_d   = emit_v - RUN_W'(1);
						end
						res_last = fin_q && cnt_d == '0 && emit_d == '0;
					end
				end
				default: begin
				end
			endcase
		end

		// closed run into the memory, then the separator into its own slot
		if (enq_run) begin
			if (cnt_d < QCNT_W'(RUN_QUEUE_DEPTH)) begin
				wr_en   = 1'b1;
				wr_addr = slot_at(head_q, cnt_d);
				wr_data = enq_val;
				cnt_d   = cnt_d + QCNT_W'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end
		if (enq_sep) begin
			sepf_d = 1'b1;
			if (cnt_d < QCNT_W'(RUN_QUEUE_DEPTH)) begin
				sep_in_d  = 1'b1;
				sep_idx_d = slot_at(head_q, cnt_d);
				cnt_d     = cnt_d + QCNT_W'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			run_queue_q[wr_addr] <= wr_data;
		rdata_q    <= run_queue_q[head_d];
		byp_data_q <= wr_data;
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd_t'(command);
			byte_s1 <= data_byte;
		end
		if (fire_s1 && cmd_s1 == CMD_PULL) begin
			entry_byte_q <= res_byte;
			available_q  <= res_avail;
			is_last_q    <= res_last;
			overflow_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			byp_q       <= 1'b0;
			sentinel_q  <= '0;
			sym_q       <= '0;
			run_q       <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			emit_q      <= '0;
			wbi_q       <= '0;
			fin_q       <= 1'b0;
			sepf_q      <= 1'b0;
			ovf_q       <= 1'b0;
			sep_in_q    <= 1'b0;
			sep_idx_q   <= '0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (fire_s1)
				valid_s1 <= 1'b0;
			if (fire_s1 && cmd_s1 == CMD_PULL)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			byp_q <= wr_en && wr_addr == head_d;
			if (cfg_valid && cfg_ready)
				sentinel_q <= cfg_data;
			sym_q     <= sym_d;
			run_q     <= run_d;
			pos_q     <= pos_d;
			cnt_q     <= cnt_d;
			head_q    <= head_d;
			emit_q    <= emit_d;
			wbi_q     <= wbi_d;
			fin_q     <= fin_d;
			sepf_q    <= sepf_d;
			ovf_q     <= ovf_d;
			sep_in_q  <= sep_in_d;
			sep_idx_q <= sep_idx_d;
		end
	end

	`RLA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(RUN_QUEUE_DEPTH), "queue count past depth")
	`RLA_ASSERT_NOW(a_sep_flag, sep_in_q, sepf_q, "separator queued without its flag")
	`RLA_ASSERT_NOW(a_last_avail, out_valid_q && is_last_q, available_q && fin_q,
		"last byte without data or before finish")
	`RLA_ASSERT_NEXT(a_fin_sticky, fin_q, fin_q, "finish flag cleared")

endmodule

/* sim/run_length_annotator_unit_tb.sv */
// self-checking testbench of the run-length annotator: predicts every pulled entry byte
`timescale 1ns / 1ps

module run_length_annotator_unit_tb
	import rla_pkg::*;
();

	localparam int DIGIT_MASK = 'h3f;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] entry_byte;
		logic       available;
		logic       is_last;
		logic       overflow;
	} entry_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       command = CMD_NONE;
	logic [7:0]       data_byte = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       entry_byte;
	logic             available;
	logic             is_last;
	logic             overflow;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [RUN_W-1:0] cfg_data = '0;

	// predicted state of the annotator
	logic [RUN_W-1:0] sentinel_reg = '0;
	logic [7:0]       run_sym = 8'h00;
	int unsigned      run_len = 0;
	int unsigned      pos_count = 0;
	int unsigned      run_fifo[$];
	int unsigned      emit_left = 0;
	int               word_idx = 0;
	bit               finished = 1'b0;
	bit               sep_done = 1'b0;
	bit               ovf_flag = 1'b0;

	entry_t expected_entries[$];

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int fail_count = 0;
	int checked_count = 0;
	int useful_items = 0;
	int push_count = 0;
	int pull_count = 0;
	int long_words = 0;

	run_length_annotator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.entry_byte(entry_byte),
		.available (available),
		.is_last   (is_last),
		.overflow  (overflow),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("run_length_annotator_unit regression: fail");
		$finish;
	end

	function automatic void queue_run(input int unsigned len);
		if (run_fifo.size() >= RUN_QUEUE_DEPTH)
			ovf_flag = 1'b1;
		else
			run_fifo.push_back(len & MAX_RUN);
	endfunction

	function automatic void close_open_run();
		if (run_len > 0)
			queue_run(run_len);
		run_len = 0;
	endfunction

	function automatic void annotate_item(input cmd_t op, input logic [7:0] val);
		entry_t e;
		case (op)
			CMD_PUSH: begin
				if (!finished) begin
					useful_items++;
					push_count++;
					if (!sep_done && pos_count == sentinel_reg) begin
						close_open_run();
						queue_run(1);
						sep_done = 1'b1;
					end
					if (run_len > 0 && val == run_sym) begin
						if (run_len >= MAX_RUN) begin
							ovf_flag = 1'b1;
							close_open_run();
							run_len = 1;
						end else begin
							run_len++;
						end
					end else begin
						close_open_run();
						run_sym = val;
						run_len = 1;
					end
					if (pos_count < MAX_POS)
						pos_count++;
				end
			end
			CMD_FINISH: begin
				if (!finished) begin
					useful_items++;
					close_open_run();
					if (!sep_done) begin
						queue_run(1);
						sep_done = 1'b1;
					end
					finished = 1'b1;
				end
			end
			CMD_PULL: begin
				useful_items++;
				pull_count++;
				e = '0;
				if (emit_left == 0 && run_fifo.size() > 0) begin
					emit_left = run_fifo.pop_front();
					word_idx = 0;
				end
				if (emit_left > 0) begin
					e.available = 1'b1;
					if (emit_left >= LONG_RUN_LIMIT || word_idx != 0) begin
						e.entry_byte = 8'((emit_left >> (6 * word_idx)) & DIGIT_MASK);
						if (word_idx == 0) begin
							e.entry_byte |= WORD_FLAG;
							long_words++;
						end
						if (word_idx == 3) begin
							word_idx = 0;
							emit_left -= 4;
						end else begin
							word_idx++;
						end
					end else begin
						e.entry_byte = SHORT_FLAG | 8'(emit_left);
						emit_left--;
					end
					if (finished && run_fifo.size() == 0 && emit_left == 0)
						e.is_last = 1'b1;
				end
				e.overflow = ovf_flag;
				expected_entries.push_back(e);
			end
			default: ;
		endcase
	endfunction

	task automatic compare_field(input string fname, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	task automatic check_entry();
		entry_t want;
		if (expected_entries.size() == 0) begin
			$display("%0t: unexpected item, expected none, actual entry_byte %0h", $time,
				entry_byte);
			fail_count++;
		end else begin
			want = expected_entries.pop_front();
			compare_field("entry_byte", want.entry_byte, entry_byte);
			compare_field("available", want.available, available);
			compare_field("is_last", want.is_last, is_last);
			compare_field("overflow", want.overflow, overflow);
			checked_count++;
		end
	endtask

	// receiver: checks each accepted item, stalls at random or for a hold-off
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			check_entry();
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	task automatic send_item(input cmd_t op, input logic [7:0] val);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= op;
		data_byte <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		annotate_item(op, val);
	endtask

	task automatic pull_all();
		while (run_fifo.size() != 0 || emit_left != 0)
			send_item(CMD_PULL, 8'($urandom));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sentinel(input logic [RUN_W-1:0] pos);
		cfg_valid <= 1'b1;
		cfg_data  <= pos;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sentinel_reg = pos;
	endtask

	task automatic test_directed();
		send_item(CMD_PULL, 8'hff);
		send_item(CMD_NONE, 8'hff);
		send_item(CMD_PUSH, 8'h00);
		send_item(CMD_PUSH, 8'h00);
		send_item(CMD_PUSH, 8'hff);
		send_item(CMD_PUSH, 8'haa);
		send_item(CMD_PUSH, 8'haa);
		send_item(CMD_PUSH, 8'haa);
		send_item(CMD_PUSH, 8'h55);
		repeat (7) send_item(CMD_PULL, 8'h00);
		send_item(CMD_NONE, 8'h00);
	endtask

	// a run of equal bytes is cut where the separator goes in
	task automatic test_sentinel_split();
		logic [7:0] sym;
		settle();
		write_sentinel(RUN_W'(pos_count + $urandom_range(30, 4)));
		while (!sep_done) begin
			sym = 8'($urandom);
			repeat ($urandom_range(6, 1)) send_item(CMD_PUSH, sym);
		end
		repeat (3) send_item(CMD_PUSH, sym);
		send_item(CMD_PUSH, ~sym);
		pull_all();
	endtask

	task automatic random_traffic(input int n);
		int stop_at;
		int kind;
		int len;
		logic [7:0] sym;
		stop_at = useful_items + n;
		while (useful_items < stop_at) begin
			kind = $urandom_range(99, 0);
			if (kind < 15) begin
				case ($urandom_range(2, 0))
					0: send_item(CMD_PUSH, 8'($urandom));
					1: send_item(CMD_PULL, 8'($urandom));
					default: send_item(CMD_NONE, 8'($urandom));
				endcase
			end else begin
				kind = $urandom_range(99, 0);
				if (kind < 60)
					len = $urandom_range(3, 1);
				else if (kind < 85)
					len = $urandom_range(20, 4);
				else if (kind < 97)
					len = $urandom_range(70, 60);
				else
					len = $urandom_range(160, 100);
				sym = 8'($urandom);
				repeat (len) send_item(CMD_PUSH, sym);
				if ($urandom_range(99, 0) < 40)
					pull_all();
				else
					repeat ($urandom_range(6, 0)) send_item(CMD_PULL, 8'($urandom));
			end
		end
	endtask

	// receiver holds off while pulls keep coming, so the unit stalls its input
	task automatic test_backpressure();
		repeat (5) send_item(CMD_PUSH, 8'($urandom));
		in_valid <= 1'b0;
		@(negedge clk);
		hold_left = 300;
		@(posedge clk);
		repeat (40) send_item(CMD_PULL, 8'($urandom));
		pull_all();
	endtask

	task automatic test_queue_overflow();
		pull_all();
		for (int i = 0; i < 70; i++)
			send_item(CMD_PUSH, i[0] ? 8'hf0 : 8'h0f);
		pull_all();
	endtask

	// finish, drain to the last byte, then everything but pulls is ignored
	task automatic test_finish_block();
		send_item(CMD_PUSH, 8'h3c);
		send_item(CMD_FINISH, 8'($urandom));
		pull_all();
		repeat (3) send_item(CMD_PULL, 8'($urandom));
		send_item(CMD_PUSH, 8'hff);
		send_item(CMD_FINISH, 8'h00);
		send_item(CMD_NONE, 8'h5a);
		send_item(CMD_PULL, 8'h00);
		repeat (10) send_item(CMD_PUSH, 8'h11);
		repeat (4) send_item(CMD_PULL, 8'hff);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 27;
		recv_stall_pct = 49;
		write_sentinel(MAX_RUN);
		test_directed();
		test_sentinel_split();
		random_traffic(150);
		settle();
		send_gap_pct = 49;
		recv_stall_pct = 27;
		write_sentinel('0);
		random_traffic(150);
		settle();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		write_sentinel(RUN_W'($urandom));
		random_traffic(110);
		test_backpressure();
		test_queue_overflow();
		test_finish_block();
		settle();
		repeat (16) @(posedge clk);
		$display("covered %0d pushes and %0d pulls, %0d entry bytes checked, %0d long-run words",
			push_count, pull_count, checked_count, long_words);
		$display("separator placed: %0b, run queue overflow reached: %0b, block finished: %0b",
			sep_done, ovf_flag, finished);
		if (fail_count == 0)
			$display("run_length_annotator_unit regression: pass");
		else
			$display("run_length_annotator_unit regression: fail");
		$finish;
	end

endmodule

/* run_length_annotator_unit.f */
+incdir+hw/rtl
hw/rtl/rla_pkg.sv
hw/rtl/run_length_annotator_unit.sv
sim/run_length_annotator_unit_tb.sv
